// ===== rtl/core/run_pair_block_writer_crc_core_assert.svh =====
// Assertion macros for the run-pair block writer RTL.
`ifndef RUN_PAIR_BLOCK_WRITER_CRC_CORE_ASSERT_SVH
`define RUN_PAIR_BLOCK_WRITER_CRC_CORE_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define RPBW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define RPBW_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/rpbw_pkg.sv =====
// Types, constants, microcode and CRC table for the run-pair block writer.
package rpbw_pkg;

  localparam int PosBits = 20;
  localparam int BlockPosW = 20;
  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [31:0] CrcStartReset = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CmdAddRun    = 2'd0,
    CmdReadMap   = 2'd1,
    CmdNewBlock  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] run_byte;
    logic [7:0] run_length;
    logic [1:0] map_word_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic [BlockPosW-1:0] block_position;
    logic                 last_of_run;
    logic [31:0]          running_crc;
    logic [63:0]          map_word;
  } out_item_t;

  // Sequencer jump kinds
  typedef enum logic [1:0] {
    JmpNext     = 2'd0,
    JmpDispatch = 2'd1,
    JmpLoopCrc  = 2'd2,
    JmpLoopEmit = 2'd3
  } jmp_e;

  localparam int StepCount = 7;
  localparam int StepW = 3;

  localparam logic [StepW-1:0] StFetch   = 3'd0;
  localparam logic [StepW-1:0] StCrc     = 3'd1;
  localparam logic [StepW-1:0] StMark    = 3'd2;
  localparam logic [StepW-1:0] StNewBlk  = 3'd3;
  localparam logic [StepW-1:0] StReadMap = 3'd4;
  localparam logic [StepW-1:0] StStatus  = 3'd5;
  localparam logic [StepW-1:0] StEmit    = 3'd6;

  typedef struct packed {
    logic             take_in;
    logic             crc_step;
    logic             mark;
    logic             new_block;
    logic             emit;
    logic             emit_map;
    logic             data_byte;
    jmp_e             jmp;
    logic [StepW-1:0] next;
  } uop_t;

  localparam uop_t Ucode [StepCount] = '{
    '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JmpDispatch, StFetch},  // fetch
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JmpLoopCrc,  StMark},   // crc
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, JmpNext,     StEmit},   // mark
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, JmpNext,     StStatus}, // new block
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, JmpNext,     StFetch},  // read map
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, JmpNext,     StFetch},  // status
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, JmpLoopEmit, StFetch}   // emit bytes
  };

  // MSB-first CRC-32 table entry
  function automatic logic [31:0] crc_table_f(input logic [7:0] idx);
    logic [31:0] c;
    c = {idx, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CrcPoly) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/rpbw_if.sv =====
// Valid/ready channel interfaces for run input and byte output.
interface rpbw_in_if;
  import rpbw_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rpbw_out_if;
  import rpbw_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/run_pair_block_writer_crc_core.sv =====
// Run-pair block writer: run to RLE1 bytes, CRC-32, used-symbol map, position.
// Add run of length L: a fetch step, L CRC steps (one byte per cycle), a mark
// step, then min(L,4)+(L>3) emit beats, each waiting while the output is full.
// Map read/zero length/unused cmd: fetch, beat; new block: fetch, clear, beat.
// Output register lets the next beat be fetched while a result waits.
// Async active-low reset: CRC and start value all ones, map and position zero.
`include "run_pair_block_writer_crc_core_assert.svh"

module run_pair_block_writer_crc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  rpbw_in_if.sink           in_i,
  rpbw_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i
);
  import rpbw_pkg::*;

  logic [StepW-1:0]     pc_q, pc_d;
  uop_t                 uop;
  logic [31:0]          crc_start_q;
  logic [31:0]          crc_q, crc_d;
  logic [3:0][63:0]     map_q, map_d;
  logic [PosBits-1:0]   pos_q, pos_d;
  logic [7:0]           ch_q, len_q, cnt_q, cnt_d;
  logic [1:0]           widx_q;
  logic [2:0]           rem_q, rem_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;
  logic                 in_fire, out_free, emit_fire, hold, is_last, long_run;
  logic [7:0]           count_byte;

  assign uop        = Ucode[pc_q];
  assign in_i.ready = uop.take_in;
  assign in_fire    = in_i.valid & uop.take_in;
  assign out_free   = ~out_valid_q | out_o.ready;
  assign emit_fire  = uop.emit & out_free;
  assign hold       = (uop.take_in & ~in_i.valid) | (uop.emit & ~out_free);
  assign long_run   = len_q > 8'd3;
  assign count_byte = len_q - 8'd4;
  assign is_last    = (uop.jmp != JmpLoopEmit) || (rem_q == 3'd1);

  // sequencer: next step
  always_comb begin
    pc_d = pc_q;
    if (!hold) begin
      case (uop.jmp)
        JmpNext: pc_d = uop.next;
        JmpDispatch: begin
          case (in_i.data.command)
            CmdAddRun:   pc_d = (in_i.data.run_length != 8'd0) ? StCrc : StStatus;
            CmdReadMap:  pc_d = StReadMap;
            CmdNewBlock: pc_d = StNewBlk;
            default:     pc_d = StStatus;
          endcase
        end
        JmpLoopCrc:  pc_d = (cnt_q == 8'd1) ? uop.next : pc_q;
        JmpLoopEmit: pc_d = (rem_q == 3'd1) ? uop.next : pc_q;
        default:     pc_d = StFetch;
      endcase
    end
  end

  // datapath
  always_comb begin
    crc_d       = crc_q;
    map_d       = map_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    if (in_fire) begin
      cnt_d = in_i.data.run_length;
    end
    if (uop.crc_step) begin
      crc_d = {crc_q[23:0], 8'h00} ^ crc_table_f(crc_q[31:24] ^ ch_q);
      cnt_d = cnt_q - 8'd1;
    end
    if (uop.mark) begin
      map_d[ch_q[7:6]][ch_q[5:0]] = 1'b1;
      if (long_run) begin
        map_d[count_byte[7:6]][count_byte[5:0]] = 1'b1;
      end
      rem_d = long_run ? 3'd5 : len_q[2:0];
    end
    if (uop.new_block) begin
      crc_d = crc_start_q;
      map_d = '0;
      pos_d = '0;
    end
    if (emit_fire) begin
      out_valid_d          = 1'b1;
      out_d.block_position = BlockPosW'(pos_q);
      out_d.running_crc    = crc_q;
      out_d.last_of_run    = is_last;
      out_d.byte_valid     = uop.data_byte;
      out_d.map_word       = uop.emit_map ? map_q[widx_q] : 64'd0;
      out_d.out_byte       = 8'd0;
      if (uop.data_byte) begin
        // count byte goes last on long runs
        out_d.out_byte = (long_run && rem_q == 3'd1) ? count_byte : ch_q;
        pos_d          = pos_q + PosBits'(1);
        rem_d          = rem_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StFetch;
      crc_start_q <= CrcStartReset;
      crc_q       <= CrcStartReset;
      map_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      crc_q       <= crc_d;
      map_q       <= map_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        crc_start_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_fire) begin
      ch_q   <= in_i.data.run_byte;
      len_q  <= in_i.data.run_length;
      widx_q <= in_i.data.map_word_index;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `RPBW_ASSERT(a_crc_cnt_live, (pc_q == StCrc) |-> (cnt_q != 8'd0), "CRC loop count hit zero")
  `RPBW_ASSERT(a_emit_rem_range, (pc_q == StEmit) |-> (rem_q != 3'd0 && rem_q <= 3'd5), "emit count out of range")
  `RPBW_ASSERT(a_last_returns, (pc_q == StEmit && emit_fire && rem_q == 3'd1) |=> (pc_q == StFetch), "sequencer did not return after last beat")
  `RPBW_ASSERT(a_newblk_clear, (pc_q == StNewBlk) |=> (map_q == '0 && pos_q == '0), "new block left map or position set")
  `RPBW_ASSERT_NEVER(a_crc_stray, !$stable(crc_q) && !$past(pc_q == StCrc || pc_q == StNewBlk), "CRC changed outside CRC or new-block step")

endmodule

// ===== tb/sv/run_pair_block_writer_crc_core_checker.sv =====
// Checker for the run-pair block writer: predicts RLE1 beats, CRC, symbol map and position.
`timescale 1ns / 1ps

module run_pair_block_writer_crc_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpbw_in_if          run_ch_i,
  rpbw_out_if         byte_ch_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output int          mismatch_cnt_o,
  output int          pending_cnt_o
);
  import rpbw_pkg::*;

  logic [31:0]        crc_start;
  logic [31:0]        block_crc;
  logic [255:0]       sym_map;
  logic [PosBits-1:0] wr_pos;
  out_item_t          block_beats_q[$];

  // One MSB-first CRC-32 byte update, bit by bit
  function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CrcPoly) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic v, input logic [63:0] w);
    out_item_t r;
    r.out_byte       = b;
    r.byte_valid     = v;
    r.block_position = BlockPosW'(wr_pos);
    r.last_of_run    = 1'b0;
    r.running_crc    = block_crc;
    r.map_word       = w;
    block_beats_q.push_back(r);
    if (v) begin
      wr_pos = wr_pos + PosBits'(1);
    end
  endfunction

  function automatic void predict_block_beats(input in_item_t it);
    if (it.command == CmdAddRun && it.run_length != 8'd0) begin
      // CRC covers every original byte, so it is final before any beat
      for (int i = 0; i < int'(it.run_length); i++) begin
        block_crc = crc_shift_byte(block_crc, it.run_byte);
      end
      sym_map[it.run_byte] = 1'b1;
      if (it.run_length <= 8'd3) begin
        for (int i = 0; i < int'(it.run_length); i++) begin
          push_beat(it.run_byte, 1'b1, 64'd0);
        end
      end else begin
        sym_map[it.run_length - 8'd4] = 1'b1;
        for (int i = 0; i < 4; i++) begin
          push_beat(it.run_byte, 1'b1, 64'd0);
        end
        push_beat(it.run_length - 8'd4, 1'b1, 64'd0);
      end
    end else if (it.command == CmdReadMap) begin
      push_beat(8'd0, 1'b0, sym_map[{it.map_word_index, 6'd0} +: 64]);
    end else begin
      if (it.command == CmdNewBlock) begin
        block_crc = crc_start;
        sym_map   = '0;
        wr_pos    = '0;
      end
      push_beat(8'd0, 1'b0, 64'd0);
    end
    block_beats_q[block_beats_q.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic int field_bad(input string fname, input logic [63:0] want,
                                   input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      crc_start      = CrcStartReset;
      block_crc      = CrcStartReset;
      sym_map        = '0;
      wr_pos         = '0;
      block_beats_q.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o  = 0;
    end else begin
      if (byte_ch_i.valid && byte_ch_i.ready) begin
        got = byte_ch_i.data;
        if (block_beats_q.size() == 0) begin
          $error("output beat with nothing expected: %0h", got);
          mismatch_cnt_o++;
        end else begin
          want = block_beats_q.pop_front();
          mismatch_cnt_o += field_bad("out_byte", 64'(want.out_byte), 64'(got.out_byte))
                          + field_bad("byte_valid", 64'(want.byte_valid),
                                      64'(got.byte_valid))
                          + field_bad("block_position", 64'(want.block_position),
                                      64'(got.block_position))
                          + field_bad("last_of_run", 64'(want.last_of_run),
                                      64'(got.last_of_run))
                          + field_bad("running_crc", 64'(want.running_crc),
                                      64'(got.running_crc))
                          + field_bad("map_word", want.map_word, got.map_word);
        end
      end
      if (cfg_we_i) begin
        crc_start = cfg_wdata_i;
      end
      if (run_ch_i.valid && run_ch_i.ready) begin
        predict_block_beats(run_ch_i.data);
      end
      pending_cnt_o = block_beats_q.size();
    end
  end

endmodule

// ===== tb/sv/run_pair_block_writer_crc_core_tb.sv =====
// Top of the run-pair block writer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module run_pair_block_writer_crc_core_tb;
  import rpbw_pkg::*;

  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam int         CycleLimit = 1_000_000;
  localparam int         TailCycles = 300;
  localparam int         PhaseBeats = 132;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          mismatch_cnt;
  int          pending_cnt;
  int          src_idle_pct;
  int          snk_idle_pct;
  int          cycle_cnt;

  rpbw_in_if  run_ch ();
  rpbw_out_if byte_ch ();

  run_pair_block_writer_crc_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (run_ch),
    .out_o       (byte_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  run_pair_block_writer_crc_core_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .run_ch_i       (run_ch),
    .byte_ch_i      (byte_ch),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    byte_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      byte_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b,
                           input logic [7:0] len, input logic [1:0] idx);
    in_item_t it;
    it.command        = cmd;
    it.run_byte       = b;
    it.run_length     = len;
    it.map_word_index = idx;
    while ($urandom_range(99) < src_idle_pct) begin
      run_ch.valid <= 1'b0;
      run_ch.data  <= 20'($urandom_range(20'hF_FFFF));
      @(negedge clk_i);
    end
    run_ch.valid <= 1'b1;
    run_ch.data  <= it;
    @(posedge clk_i);
    while (!run_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Only with the block drained
  task automatic write_crc_start(input logic [31:0] v);
    run_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int          sel;
    int          lsel;
    logic [1:0]  cmd;
    logic [7:0]  len;
    logic [31:0] start_val;

    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    run_ch.valid  = 1'b0;
    run_ch.data   = '0;
    src_idle_pct  = 22;
    snk_idle_pct  = 79;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short, boundary, zero-length and long runs under the reset start value, then map reads and an unused command
    send_beat(CmdAddRun, 8'h41, 8'd1, 2'd0);
    send_beat(CmdAddRun, 8'h00, 8'd2, 2'd1);
    send_beat(CmdAddRun, 8'hFF, 8'd3, 2'd2);
    send_beat(CmdAddRun, 8'h5A, 8'd4, 2'd3);
    send_beat(CmdAddRun, 8'hA5, 8'd5, 2'd0);
    send_beat(CmdAddRun, 8'h3C, 8'd0, 2'd3);
    send_beat(CmdAddRun, 8'hFF, 8'd255, 2'd0);
    send_beat(CmdAddRun, 8'h80, 8'd132, 2'd1);
    send_beat(CmdReadMap, 8'h00, 8'd0, 2'd0);
    send_beat(CmdReadMap, 8'hFF, 8'hFF, 2'd1);
    send_beat(CmdReadMap, 8'h00, 8'd0, 2'd2);
    send_beat(CmdReadMap, 8'h00, 8'd0, 2'd3);
    send_beat(CmdUnused, 8'h12, 8'd9, 2'd2);

    write_crc_start(32'h0000_0000);
    send_beat(CmdNewBlock, 8'hFF, 8'hFF, 2'd3);
    send_beat(CmdAddRun, 8'h7E, 8'd7, 2'd0);
    send_beat(CmdReadMap, 8'h00, 8'd0, 2'd1);
    send_beat(CmdReadMap, 8'h00, 8'd0, 2'd0);

    write_crc_start(32'hFFFF_FFFF);
    send_beat(CmdNewBlock, 8'h00, 8'd0, 2'd0);
    send_beat(CmdAddRun, 8'h00, 8'd255, 2'd2);
    send_beat(CmdReadMap, 8'h00, 8'd0, 2'd3);
    send_beat(CmdReadMap, 8'h00, 8'd0, 2'd0);
    send_beat(CmdUnused, 8'hFF, 8'hFF, 2'd3);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 22;
          snk_idle_pct = 79;
          start_val    = 32'h0000_0000;
        end
        1: begin
          src_idle_pct = 79;
          snk_idle_pct = 22;
          start_val    = 32'hFFFF_FFFF;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          start_val    = $urandom();
        end
      endcase
      write_crc_start(start_val);
      send_beat(CmdNewBlock, 8'($urandom_range(255)), 8'($urandom_range(255)),
                2'($urandom_range(3)));
      for (int n = 0; n < PhaseBeats; n++) begin
        sel  = $urandom_range(99);
        lsel = $urandom_range(99);
        // mostly short runs, a few long ones to walk the count byte range
        if (lsel < 5)       len = 8'd0;
        else if (lsel < 75) len = 8'($urandom_range(6, 1));
        else if (lsel < 92) len = 8'($urandom_range(40, 7));
        else                len = 8'($urandom_range(255, 41));
        if (sel < 70) begin
          cmd = CmdAddRun;
        end else if (sel < 85) begin
          cmd = CmdReadMap;
          len = 8'($urandom_range(255));
        end else if (sel < 92) begin
          cmd = CmdNewBlock;
          len = 8'($urandom_range(255));
        end else begin
          cmd = CmdUnused;
          len = 8'($urandom_range(255));
        end
        send_beat(cmd, 8'($urandom_range(255)), len, 2'($urandom_range(3)));
      end
    end

    run_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rpbw_pkg.sv
rtl/core/rpbw_if.sv
rtl/core/run_pair_block_writer_crc_core.sv
tb/sv/run_pair_block_writer_crc_core_checker.sv
tb/sv/run_pair_block_writer_crc_core_tb.sv
